// ===== design/att_pkg.sv =====
// package for the allocation tracking table unit
// table sizes, request and status codes, sequencer states and the stored entry type
// no dependencies

package att_pkg;

   localparam int TABLE_DEPTH   = 1024;
   localparam int GROW_STEP     = 64;
   localparam int ADDRESS_WIDTH = 32;

   // fixed field widths of the request and response words
   localparam int ADDR_FIELD_W = 32;
   localparam int TAG_W        = 16;
   localparam int SLOT_W       = 10;
   localparam int HWM_W        = 11;

   localparam int IDX_W    = $clog2(TABLE_DEPTH);
   localparam int MARK_W   = $clog2(TABLE_DEPTH + 1);
   localparam int LAST_IDX = TABLE_DEPTH - 1;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_UPDATE = 2'd1,
      OP_REMOVE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RDWAIT,
      ST_SEARCH,
      ST_WRITE,
      ST_LOWER,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [ADDRESS_WIDTH-1:0] addr;
      logic [TAG_W-1:0]         site;
      logic [TAG_W-1:0]         line;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== design/allocation_tracking_table_unit.sv =====
// allocation tracking table: top level with the request sequencer and response register
// depends on att_pkg and att_ram
//
// usage
//   request word (req_valid / req_stall): req_type selects add, update, remove or read.
//   add stores req_new_address, req_site_id and req_line_number in the highest empty
//   slot under the high-water mark, or raises the mark by one grow step and uses the new
//   top slot; if that would pass the table depth the word is dropped with status full.
//   update and remove act on the highest slot under the mark holding req_match_address;
//   remove clears it and then walks the mark down past empty top slots.
//   read returns the entry at req_read_index, independent of the mark.
//   response word (rsp_valid / rsp_stall): one word per request, in order.
// throughput
//   one request at a time; all entries live in one ram with a single read port, and every
//   search walks it one slot per cycle from the mark downward.
//   remove walks a second time, lowering the mark.
// reset
//   synchronous reset clears the mark and starts a clearing pass that writes every ram
//   entry to zero, one per cycle, with req_stall high meanwhile.
// back-pressure
//   the response sits in an output register; while rsp_stall holds it, the next request
//   is still accepted and worked on, and only its own response waits for the register.

module allocation_tracking_table_unit
   import att_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_type,
   input  logic [ADDR_FIELD_W-1:0] req_match_address,
   input  logic [ADDR_FIELD_W-1:0] req_new_address,
   input  logic [TAG_W-1:0]        req_site_id,
   input  logic [TAG_W-1:0]        req_line_number,
   input  logic [SLOT_W-1:0]       req_read_index,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [SLOT_W-1:0]       rsp_slot_index,
   output logic [HWM_W-1:0]        rsp_high_water,
   output logic                    rsp_entry_live,
   output logic [ADDR_FIELD_W-1:0] rsp_entry_address,
   output logic [TAG_W-1:0]        rsp_entry_site,
   output logic [TAG_W-1:0]        rsp_entry_line
);

   // control state
   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        clr_ff, clr_in;
   logic [MARK_W-1:0]       mark_ff, mark_in;
   logic [MARK_W-1:0]       scan_ff, scan_in;      // next slot + 1 to read in a walk
   logic                    pend_ff, pend_in;      // a read is in flight this cycle
   logic                    rsp_valid_ff, rsp_valid_in;

   // request and result holding registers
   logic [IDX_W-1:0]         rd_idx_ff, rd_idx_in; // slot whose data arrives now
   logic [IDX_W-1:0]         slot_ff, slot_in;
   op_type                   op_ff, op_in;
   logic [ADDRESS_WIDTH-1:0] key_ff, key_in;
   entry_type                new_ff, new_in;
   logic [1:0]               res_status_ff, res_status_in;
   logic [SLOT_W-1:0]        res_slot_ff, res_slot_in;
   logic                     res_live_ff, res_live_in;
   logic [ADDR_FIELD_W-1:0]  res_addr_ff, res_addr_in;
   logic [TAG_W-1:0]         res_site_ff, res_site_in;
   logic [TAG_W-1:0]         res_line_ff, res_line_in;

   // output register
   logic [1:0]              out_status_ff, out_status_in;
   logic [SLOT_W-1:0]       out_slot_ff, out_slot_in;
   logic [HWM_W-1:0]        out_hwm_ff, out_hwm_in;
   logic                    out_live_ff, out_live_in;
   logic [ADDR_FIELD_W-1:0] out_addr_ff, out_addr_in;
   logic [TAG_W-1:0]        out_site_ff, out_site_in;
   logic [TAG_W-1:0]        out_line_ff, out_line_in;

   // ram ports
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   entry_type        ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata_raw;
   entry_type        ram_rdata;

   logic              req_accept;
   logic [MARK_W-1:0] scan_dec;
   logic              can_grow;
   logic              out_free;

   att_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata_raw)
   );

   assign ram_rdata  = entry_type'(ram_rdata_raw);
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign scan_dec   = scan_ff - MARK_W'(1);
   assign can_grow   = (32'(mark_ff) + 32'(GROW_STEP)) <= 32'(TABLE_DEPTH);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         mark_ff      <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         mark_ff      <= mark_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      slot_ff       <= slot_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      new_ff        <= new_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_live_ff   <= res_live_in;
      res_addr_ff   <= res_addr_in;
      res_site_ff   <= res_site_in;
      res_line_ff   <= res_line_in;
      out_status_ff <= out_status_in;
      out_slot_ff   <= out_slot_in;
      out_hwm_ff    <= out_hwm_in;
      out_live_ff   <= out_live_in;
      out_addr_ff   <= out_addr_in;
      out_site_ff   <= out_site_in;
      out_line_ff   <= out_line_in;
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      mark_in       = mark_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      rd_idx_in     = rd_idx_ff;
      slot_in       = slot_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      new_in        = new_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_live_in   = res_live_ff;
      res_addr_in   = res_addr_ff;
      res_site_in   = res_site_ff;
      res_line_in   = res_line_ff;

      ram_we    = 1'b0;
      ram_waddr = slot_ff;
      ram_wdata = new_ff;
      ram_raddr = rd_idx_ff;

      // output register drains when taken
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      out_status_in = out_status_ff;
      out_slot_in   = out_slot_ff;
      out_hwm_in    = out_hwm_ff;
      out_live_in   = out_live_ff;
      out_addr_in   = out_addr_ff;
      out_site_in   = out_site_ff;
      out_line_in   = out_line_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // zero one entry per cycle after reset
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(LAST_IDX)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_accept) begin
               op_in         = op_type'(req_type);
               new_in.addr   = ADDRESS_WIDTH'(req_new_address);
               new_in.site   = req_site_id;
               new_in.line   = req_line_number;
               res_status_in = STATUS_DONE;
               res_slot_in   = '0;
               res_live_in   = 1'b0;
               res_addr_in   = '0;
               res_site_in   = '0;
               res_line_in   = '0;
               if (op_type'(req_type) == OP_READ) begin
                  ram_raddr   = IDX_W'(req_read_index);
                  res_slot_in = req_read_index;
                  if (32'(req_read_index) >= 32'(TABLE_DEPTH)) begin
                     res_status_in = STATUS_NOT_FOUND;
                  end
                  state_in = ST_RDWAIT;
               end else begin
                  // add looks for an empty slot, i.e. address zero
                  key_in   = (op_type'(req_type) == OP_ADD) ? '0
                                                           : ADDRESS_WIDTH'(req_match_address);
                  scan_in  = mark_ff;
                  state_in = ST_SEARCH;
               end
            end
         end

         ST_RDWAIT: begin
            if (res_status_ff == STATUS_DONE) begin
               res_live_in = (ram_rdata.addr != '0);
               res_addr_in = ADDR_FIELD_W'(ram_rdata.addr);
               res_site_in = ram_rdata.site;
               res_line_in = ram_rdata.line;
            end
            state_in = ST_RESP;
         end

         ST_SEARCH: begin
            // walk downward from the mark, one read issued per cycle
            if (pend_ff && (ram_rdata.addr == key_ff)) begin
               slot_in     = rd_idx_ff;
               res_slot_in = SLOT_W'(rd_idx_ff);
               state_in    = ST_WRITE;
            end else if (scan_ff != '0) begin
               ram_raddr = scan_dec[IDX_W-1:0];
               rd_idx_in = scan_dec[IDX_W-1:0];
               scan_in   = scan_dec;
               pend_in   = 1'b1;
            end else if (op_ff == OP_ADD) begin
               if (can_grow) begin
                  mark_in     = MARK_W'(32'(mark_ff) + 32'(GROW_STEP));
                  slot_in     = IDX_W'(32'(mark_ff) + 32'(GROW_STEP) - 32'd1);
                  res_slot_in = SLOT_W'(32'(mark_ff) + 32'(GROW_STEP) - 32'd1);
                  state_in    = ST_WRITE;
               end else begin
                  res_status_in = STATUS_FULL;
                  state_in      = ST_RESP;
               end
            end else begin
               res_status_in = STATUS_NOT_FOUND;
               state_in      = ST_RESP;
            end
         end

         ST_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = slot_ff;
            if (op_ff == OP_REMOVE) begin
               ram_wdata = '0;
               scan_in   = mark_ff;
               state_in  = ST_LOWER;
            end else begin
               ram_wdata = new_ff;
               state_in  = ST_RESP;
            end
         end

         ST_LOWER: begin
            // drop the mark past empty top slots; reads run one ahead of the mark
            if (pend_ff && (ram_rdata.addr != '0)) begin
               state_in = ST_RESP;
            end else begin
               if (pend_ff) begin
                  mark_in = MARK_W'(rd_idx_ff);
               end
               if (scan_ff != '0) begin
                  ram_raddr = scan_dec[IDX_W-1:0];
                  rd_idx_in = scan_dec[IDX_W-1:0];
                  scan_in   = scan_dec;
                  pend_in   = 1'b1;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end

         ST_RESP: begin
            // hand the result to the output register once it is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_slot_in   = res_slot_ff;
               out_hwm_in    = HWM_W'(mark_ff);
               out_live_in   = res_live_ff;
               out_addr_in   = res_addr_ff;
               out_site_in   = res_site_ff;
               out_line_in   = res_line_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_slot_index    = out_slot_ff;
   assign rsp_high_water    = out_hwm_ff;
   assign rsp_entry_live    = out_live_ff;
   assign rsp_entry_address = out_addr_ff;
   assign rsp_entry_site    = out_site_ff;
   assign rsp_entry_line    = out_line_ff;

endmodule

// ===== design/att_ram.sv =====
// generic simple dual-port ram: one write port, one read port, registered read data
// no dependencies

module att_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
